// ===== hdl/hte_pkg.sv =====
// ----------------------------------------------------------------------------
// hte_pkg: shared types, widths and tables for the transfer error block
// Fixed-point widths, register map, sequencer states and cofactor tables.
// ----------------------------------------------------------------------------
package hte_pkg;

  localparam int CW    = 32;           // coefficient / coordinate width
  localparam int PW    = 64;           // product and projection sum width
  localparam int FRAC  = 16;           // fraction bits of a quotient
  localparam int QINT  = 33;           // integer bits before the quotient clamps
  localparam int QMW   = QINT + FRAC;  // quotient magnitude bits
  localparam int QW    = QMW + 2;      // signed quotient, clamp value included
  localparam int DIV_LAT = QMW + 2;    // divider pipeline depth in register stages
  localparam int EW    = 48;           // error width
  localparam int NCOEF = 9;
  localparam int CIW   = 4;            // coefficient index width
  localparam int DACW  = 97;           // determinant accumulator width
  localparam int AW    = 6;            // APB address width
  localparam int DW    = 64;           // APB data width

  localparam logic [EW-1:0] ERR_MAX = '1;

  // register indexes (paddr[5:3])
  localparam logic [2:0] REG_H0_H1 = 3'd0;
  localparam logic [2:0] REG_H2_H3 = 3'd1;
  localparam logic [2:0] REG_H4_H5 = 3'd2;
  localparam logic [2:0] REG_H6_H7 = 3'd3;
  localparam logic [2:0] REG_H8    = 3'd4;

  typedef logic signed [CW-1:0] coef_t;

  typedef enum logic [5:0] {
    SQ_COF  = 6'b000001,
    SQ_DET  = 6'b000010,
    SQ_MAX  = 6'b000100,
    SQ_NORM = 6'b001000,
    SQ_ADJ  = 6'b010000,
    SQ_RDY  = 6'b100000
  } seq_state_t;

  typedef struct packed {
    coef_t x1;
    coef_t y1;
    coef_t x2;
    coef_t y2;
    logic  degen;
  } side_t;

  typedef struct packed {
    logic [EW-1:0] err;
    logic          sat;
    logic          degen;
  } res_t;

  // cofactor k = h[a(2k)]*h[b(2k)] - h[a(2k+1)]*h[b(2k+1)]
  function automatic logic [CIW-1:0] cof_opa(input logic [4:0] step);
    logic [CIW-1:0] r;
    case (step)
      5'd0:  r = 4'd4;  5'd1:  r = 4'd5;
      5'd2:  r = 4'd5;  5'd3:  r = 4'd3;
      5'd4:  r = 4'd3;  5'd5:  r = 4'd4;
      5'd6:  r = 4'd2;  5'd7:  r = 4'd1;
      5'd8:  r = 4'd0;  5'd9:  r = 4'd2;
      5'd10: r = 4'd1;  5'd11: r = 4'd0;
      5'd12: r = 4'd1;  5'd13: r = 4'd2;
      5'd14: r = 4'd2;  5'd15: r = 4'd0;
      5'd16: r = 4'd0;  5'd17: r = 4'd1;
      default: r = 4'd0;
    endcase
    return r;
  endfunction

  function automatic logic [CIW-1:0] cof_opb(input logic [4:0] step);
    logic [CIW-1:0] r;
    case (step)
      5'd0:  r = 4'd8;  5'd1:  r = 4'd7;
      5'd2:  r = 4'd6;  5'd3:  r = 4'd8;
      5'd4:  r = 4'd7;  5'd5:  r = 4'd6;
      5'd6:  r = 4'd7;  5'd7:  r = 4'd8;
      5'd8:  r = 4'd8;  5'd9:  r = 4'd6;
      5'd10: r = 4'd6;  5'd11: r = 4'd7;
      5'd12: r = 4'd5;  5'd13: r = 4'd4;
      5'd14: r = 4'd3;  5'd15: r = 4'd5;
      5'd16: r = 4'd4;  5'd17: r = 4'd3;
      default: r = 4'd0;
    endcase
    return r;
  endfunction

  // adjugate is the transposed cofactor matrix
  function automatic logic [CIW-1:0] adj_src(input logic [CIW-1:0] idx);
    logic [CIW-1:0] r;
    case (idx)
      4'd0: r = 4'd0;
      4'd1: r = 4'd3;
      4'd2: r = 4'd6;
      4'd3: r = 4'd1;
      4'd4: r = 4'd4;
      4'd5: r = 4'd7;
      4'd6: r = 4'd2;
      4'd7: r = 4'd5;
      4'd8: r = 4'd8;
      default: r = 4'd0;
    endcase
    return r;
  endfunction

endpackage

// ===== hdl/homography_transfer_error_top.sv =====
// ----------------------------------------------------------------------------
// homography_transfer_error_top: symmetric transfer error of a point match
// Maps p1 by H and p2 by adj(H), divides by w, returns half the summed
// squared distances with saturation and degenerate flags.
// ----------------------------------------------------------------------------
// Takes one item per clock when out_ready stays high and the sequencer is
// ready; each item's result passes 58 register stages, the first loaded at
// the edge that accepts it: two projection stages, the 51-stage restoring
// divider, four error stages, the output register. The divider, one
// quotient bit per stage, sets the latency. One result can wait in the
// output register while a further item is still taken (skid register). After
// reset and after every register write, a sequencer with one shared 33x33
// multiplier rebuilds the adjugate and the determinant test: 18 cofactor
// products, 6 determinant partial products, a largest-magnitude search,
// normalizing shifts and 9 adjugate writes, with in_ready low throughout.
// Registers sit at byte address 8*i on a 64-bit APB port.
// ----------------------------------------------------------------------------
module homography_transfer_error_top (
  input  logic                          clk,
  input  logic                          rst,
  // APB register port
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [hte_pkg::AW-1:0]        paddr,
  input  logic [hte_pkg::DW-1:0]        pwdata,
  output logic [hte_pkg::DW-1:0]        prdata,
  output logic                          pready,
  // input items
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [hte_pkg::CW-1:0] first_x,
  input  logic signed [hte_pkg::CW-1:0] first_y,
  input  logic signed [hte_pkg::CW-1:0] second_x,
  input  logic signed [hte_pkg::CW-1:0] second_y,
  // result items
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [hte_pkg::EW-1:0]        transfer_error,
  output logic                          saturated,
  output logic                          degenerate
);
  import hte_pkg::*;

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [DW-1:0] h01, h23, h45, h67;
  logic [CW-1:0] h8r;
  logic          cfg_wr;
  logic [2:0]    cfg_idx;
  coef_t         h [NCOEF];

  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite;
  assign cfg_idx = paddr[AW-1:3];

  always_ff @(posedge clk) begin
    if (rst) begin
      h01 <= {32'h0001_0000, 32'h0};
      h23 <= '0;
      h45 <= {32'h0001_0000, 32'h0};
      h67 <= '0;
      h8r <= 32'h0001_0000;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_H0_H1: h01 <= pwdata;
        REG_H2_H3: h23 <= pwdata;
        REG_H4_H5: h45 <= pwdata;
        REG_H6_H7: h67 <= pwdata;
        REG_H8:    h8r <= pwdata[CW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_H0_H1: prdata = h01;
      REG_H2_H3: prdata = h23;
      REG_H4_H5: prdata = h45;
      REG_H6_H7: prdata = h67;
      REG_H8:    prdata = {{(DW-CW){1'b0}}, h8r};
      default:   prdata = '0;
    endcase
  end

  // H row-major
  assign h[0] = h01[63:32];
  assign h[1] = h01[31:0];
  assign h[2] = h23[63:32];
  assign h[3] = h23[31:0];
  assign h[4] = h45[63:32];
  assign h[5] = h45[31:0];
  assign h[6] = h67[63:32];
  assign h[7] = h67[31:0];
  assign h[8] = h8r;

  // --------------------------------------------------------------------------
  // Adjugate / determinant sequencer (one shared multiplier, product register)
  // --------------------------------------------------------------------------
  seq_state_t           seq_state;
  logic [4:0]           cnt;
  logic signed [PW-1:0] cof [NCOEF];
  coef_t                adj [NCOEF];
  logic signed [CW:0]   ma, mb;
  logic signed [2*CW+1:0] prod, preg;
  logic                 pval, pdet;
  logic [4:0]           pstep;
  logic [DACW-1:0]      dacc;
  logic [PW-1:0]        mx, cmag;
  logic [5:0]           shamt;
  logic signed [PW-1:0] adj_shift;
  logic                 det_zero;
  logic                 seq_rdy;
  logic [1:0]           dk;

  assign dk      = cnt[2:1];
  assign seq_rdy = (seq_state == SQ_RDY);

  always_comb begin
    ma = '0;
    mb = '0;
    case (seq_state)
      SQ_COF: begin
        ma = {h[cof_opa(cnt)][CW-1], h[cof_opa(cnt)]};
        mb = {h[cof_opb(cnt)][CW-1], h[cof_opb(cnt)]};
      end
      SQ_DET: begin
        ma = {h[CIW'(dk)][CW-1], h[CIW'(dk)]};
        mb = cnt[0] ? {cof[CIW'(dk)][PW-1], cof[CIW'(dk)][PW-1:CW]}
                    : {1'b0, cof[CIW'(dk)][CW-1:0]};
      end
      default: ;
    endcase
  end

  assign prod      = ma * mb;
  assign cmag      = cof[cnt[3:0]][PW-1] ? PW'(-cof[cnt[3:0]]) : PW'(cof[cnt[3:0]]);
  assign adj_shift = cof[adj_src(cnt[3:0])] >>> shamt;

  always_ff @(posedge clk) begin
    if (rst || cfg_wr) begin
      seq_state <= SQ_COF;
      cnt       <= '0;
      pval      <= 1'b0;
      pdet      <= 1'b0;
      pstep     <= '0;
      dacc      <= '0;
      mx        <= '0;
      shamt     <= '0;
    end else begin
      pval  <= (seq_state == SQ_COF) || (seq_state == SQ_DET);
      pdet  <= (seq_state == SQ_DET);
      pstep <= cnt;
      if (pval && pdet) begin
        dacc <= dacc + (pstep[0] ? ({{(DACW-2*CW-2){preg[2*CW+1]}}, preg} << CW)
                                 : {{(DACW-2*CW-2){preg[2*CW+1]}}, preg});
      end
      case (seq_state)
        SQ_COF: begin
          if (cnt == 5'd17) begin
            seq_state <= SQ_DET;
            cnt       <= '0;
          end else begin
            cnt <= cnt + 5'd1;
          end
        end
        SQ_DET: begin
          if (cnt == 5'd5) begin
            seq_state <= SQ_MAX;
            cnt       <= '0;
          end else begin
            cnt <= cnt + 5'd1;
          end
        end
        SQ_MAX: begin
          if (cmag > mx) begin
            mx <= cmag;
          end
          if (cnt == 5'd8) begin
            seq_state <= SQ_NORM;
            cnt       <= '0;
          end else begin
            cnt <= cnt + 5'd1;
          end
        end
        SQ_NORM: begin
          // shift until the largest cofactor fits below 2^31
          if (mx[PW-1:CW-1] != '0) begin
            mx    <= mx >> 1;
            shamt <= shamt + 6'd1;
          end else begin
            seq_state <= SQ_ADJ;
          end
        end
        SQ_ADJ: begin
          if (cnt == 5'd8) begin
            seq_state <= SQ_RDY;
            cnt       <= '0;
          end else begin
            cnt <= cnt + 5'd1;
          end
        end
        SQ_RDY: ;
        default: seq_state <= SQ_COF;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    preg     <= prod;
    det_zero <= (dacc == '0);
    if (pval && !pdet) begin
      cof[pstep[4:1]] <= pstep[0] ? cof[pstep[4:1]] - preg[PW-1:0] : preg[PW-1:0];
    end
    if (seq_state == SQ_ADJ) begin
      adj[cnt[3:0]] <= adj_shift[CW-1:0];
    end
  end

  // --------------------------------------------------------------------------
  // Item pipeline, one global enable held off only by a full skid register
  // --------------------------------------------------------------------------
  logic en, in_acc;
  logic skid_valid;

  assign en       = ~skid_valid;
  assign in_ready = en & seq_rdy;
  assign in_acc   = in_valid & in_ready;

  // S1: the twelve projection products
  logic                 v1;
  logic signed [PW-1:0] pf [6];
  logic signed [PW-1:0] pb [6];
  coef_t                s1x1, s1y1, s1x2, s1y2;

  always_ff @(posedge clk) begin
    if (en) begin
      pf[0] <= h[0] * first_x;
      pf[1] <= h[1] * first_y;
      pf[2] <= h[3] * first_x;
      pf[3] <= h[4] * first_y;
      pf[4] <= h[6] * first_x;
      pf[5] <= h[7] * first_y;
      pb[0] <= adj[0] * second_x;
      pb[1] <= adj[1] * second_y;
      pb[2] <= adj[3] * second_x;
      pb[3] <= adj[4] * second_y;
      pb[4] <= adj[6] * second_x;
      pb[5] <= adj[7] * second_y;
      s1x1  <= first_x;
      s1y1  <= first_y;
      s1x2  <= second_x;
      s1y2  <= second_y;
    end
  end

  // S2: u, v, w in Q.30 (products floor-shifted by 2, constant term times 2^14)
  logic                 v2;
  logic signed [PW-1:0] uf_next, vf_next, wf_next, ub_next, vb_next, wb_next;
  logic signed [PW-1:0] uf, vf, wf, ub, vb, wb;
  side_t                s2;

  always_comb begin
    uf_next = (pf[0] >>> 2) + (pf[1] >>> 2) + (PW'(h[2]) <<< 14);
    vf_next = (pf[2] >>> 2) + (pf[3] >>> 2) + (PW'(h[5]) <<< 14);
    wf_next = (pf[4] >>> 2) + (pf[5] >>> 2) + (PW'(h[8]) <<< 14);
    ub_next = (pb[0] >>> 2) + (pb[1] >>> 2) + (PW'(adj[2]) <<< 14);
    vb_next = (pb[2] >>> 2) + (pb[3] >>> 2) + (PW'(adj[5]) <<< 14);
    wb_next = (pb[4] >>> 2) + (pb[5] >>> 2) + (PW'(adj[8]) <<< 14);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      uf       <= uf_next;
      vf       <= vf_next;
      wf       <= wf_next;
      ub       <= ub_next;
      vb       <= vb_next;
      wb       <= wb_next;
      s2.x1    <= s1x1;
      s2.y1    <= s1y1;
      s2.x2    <= s1x2;
      s2.y2    <= s1y2;
      s2.degen <= det_zero | (wf_next == '0) | (wb_next == '0);
    end
  end

  // dividers; point data and flags ride a matching delay line
  logic signed [QW-1:0] fx, fy, bx, by;
  side_t                sd  [DIV_LAT];
  logic                 sdv [DIV_LAT];

  hte_div u_div_fx (.clk(clk), .en(en), .num(uf), .den(wf), .quo(fx));
  hte_div u_div_fy (.clk(clk), .en(en), .num(vf), .den(wf), .quo(fy));
  hte_div u_div_bx (.clk(clk), .en(en), .num(ub), .den(wb), .quo(bx));
  hte_div u_div_by (.clk(clk), .en(en), .num(vb), .den(wb), .quo(by));

  always_ff @(posedge clk) begin
    if (en) begin
      sd[0] <= s2;
      for (int i = 1; i < DIV_LAT; i++) begin
        sd[i] <= sd[i-1];
      end
    end
  end

  // S3: differences, magnitude split into 17-bit integer and 16-bit fraction
  logic                   v3, big3, degen3;
  logic signed [QW:0]     df [4];
  logic [QW:0]            dm [4];
  logic [QINT-FRAC-1:0]   a3 [4];
  logic [FRAC-1:0]        b3 [4];
  logic [3:0]             bigl;

  always_comb begin
    df[0] = (QW+1)'(sd[DIV_LAT-1].x1) - (QW+1)'(bx);
    df[1] = (QW+1)'(sd[DIV_LAT-1].y1) - (QW+1)'(by);
    df[2] = (QW+1)'(fx) - (QW+1)'(sd[DIV_LAT-1].x2);
    df[3] = (QW+1)'(fy) - (QW+1)'(sd[DIV_LAT-1].y2);
    for (int i = 0; i < 4; i++) begin
      dm[i]   = df[i][QW] ? (QW+1)'(-df[i]) : (QW+1)'(df[i]);
      bigl[i] = |dm[i][QW:QINT];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 4; i++) begin
        a3[i] <= dm[i][QINT-1:FRAC];
        b3[i] <= dm[i][FRAC-1:0];
      end
      big3   <= |bigl;
      degen3 <= sd[DIV_LAT-1].degen;
    end
  end

  // S4: partial squares
  logic                      v4, big4, degen4;
  logic [2*(QINT-FRAC)-1:0]  aa4 [4];
  logic [QINT-1:0]           ab4 [4];
  logic [2*FRAC-1:0]         bb4 [4];

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 4; i++) begin
        aa4[i] <= a3[i] * a3[i];
        ab4[i] <= a3[i] * b3[i];
        bb4[i] <= b3[i] * b3[i];
      end
      big4   <= big3;
      degen4 <= degen3;
    end
  end

  // S5: per-lane high terms, pair sums, low sum
  logic                v5, big5, degen5;
  logic [QMW:0]        t5 [4];
  logic [QMW+1:0]      h01_5, h23_5;
  logic [2*FRAC+1:0]   l5;

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      t5[i] = ((QMW+1)'(aa4[i]) << (FRAC-1)) + (QMW+1)'(ab4[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      h01_5  <= (QMW+2)'(t5[0]) + (QMW+2)'(t5[1]);
      h23_5  <= (QMW+2)'(t5[2]) + (QMW+2)'(t5[3]);
      l5     <= (2*FRAC+2)'(bb4[0]) + (2*FRAC+2)'(bb4[1])
              + (2*FRAC+2)'(bb4[2]) + (2*FRAC+2)'(bb4[3]);
      big5   <= big4;
      degen5 <= degen4;
    end
  end

  // S6: total, saturation, final result
  logic             v6;
  logic [QMW+3:0]   err6;
  logic             sat6;
  res_t             r6_next, r6;

  always_comb begin
    err6 = (QMW+4)'(h01_5) + (QMW+4)'(h23_5) + (QMW+4)'(l5 >> (FRAC+1));
    sat6 = big5 | (|err6[QMW+3:EW]);
    if (degen5) begin
      r6_next = '{err: ERR_MAX, sat: 1'b0, degen: 1'b1};
    end else if (sat6) begin
      r6_next = '{err: ERR_MAX, sat: 1'b1, degen: 1'b0};
    end else begin
      r6_next = '{err: err6[EW-1:0], sat: 1'b0, degen: 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      r6 <= r6_next;
    end
  end

  // valid bits follow the data
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
      v6 <= 1'b0;
      for (int i = 0; i < DIV_LAT; i++) begin
        sdv[i] <= 1'b0;
      end
    end else if (en) begin
      v1     <= in_acc;
      v2     <= v1;
      sdv[0] <= v2;
      for (int i = 1; i < DIV_LAT; i++) begin
        sdv[i] <= sdv[i-1];
      end
      v3 <= sdv[DIV_LAT-1];
      v4 <= v3;
      v5 <= v4;
      v6 <= v5;
    end
  end

  // --------------------------------------------------------------------------
  // Output register and skid register
  // --------------------------------------------------------------------------
  res_t out_res, skid_res;
  logic out_stall;

  assign out_stall = out_valid & ~out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_stall) begin
      if (v6 && en) begin
        skid_valid <= 1'b1;
      end
    end else if (skid_valid) begin
      out_valid  <= 1'b1;
      skid_valid <= 1'b0;
    end else begin
      out_valid <= v6 & en;
    end
  end

  always_ff @(posedge clk) begin
    if (out_stall) begin
      if (v6 && en) begin
        skid_res <= r6;
      end
    end else if (skid_valid) begin
      out_res <= skid_res;
    end else if (v6 && en) begin
      out_res <= r6;
    end
  end

  assign transfer_error = out_res.err;
  assign saturated      = out_res.sat;
  assign degenerate     = out_res.degen;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_skid_blocks_input: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> !in_ready)
    else $error("input taken while skid register full");

  a_skid_fill_on_stall: assert property (@(posedge clk) disable iff (rst)
    $rose(skid_valid) |-> $past(out_valid && !out_ready))
    else $error("skid register filled without an output stall");

  a_flags_exclusive: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(saturated && degenerate))
    else $error("saturated and degenerate both set");

  a_flag_max_error: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (saturated || degenerate)) |-> (transfer_error == ERR_MAX))
    else $error("flagged result without maximum error");

  a_write_restarts: assert property (@(posedge clk) disable iff (rst)
    cfg_wr |=> (seq_state == SQ_COF) && !in_ready)
    else $error("register write did not restart adjugate sequencer");

endmodule

// ===== hdl/hte_div.sv =====
// ----------------------------------------------------------------------------
// hte_div: pipelined signed divider, Q33.16 quotient with clamp
// One restoring step per stage; magnitude clamps at 2^49 (2^33 real).
// ----------------------------------------------------------------------------
module hte_div (
  input  logic                         clk,
  input  logic                         en,
  input  logic signed [hte_pkg::PW-1:0] num,
  input  logic signed [hte_pkg::PW-1:0] den,
  output logic signed [hte_pkg::QW-1:0] quo
);
  import hte_pkg::*;

  logic [PW-1:0]   nu;
  logic [PW-1:0]   du;
  logic [PW-1:0]   rem [QMW+1];
  logic [QMW-1:0]  qn  [QMW+1];
  logic [PW-1:0]   dv  [QMW+1];
  logic            sg  [QMW+1];
  logic            ov  [QMW+1];
  logic [PW:0]     tr  [QMW];
  logic [PW:0]     tsub[QMW];
  logic            ge  [QMW];
  logic [QMW:0]    mq;

  always_comb begin
    nu = num[PW-1] ? PW'(-num) : PW'(num);
    du = den[PW-1] ? PW'(-den) : PW'(den);
  end

  always_comb begin
    for (int j = 0; j < QMW; j++) begin
      tr[j]   = {rem[j], qn[j][QMW-1]};
      tsub[j] = tr[j] - {1'b0, dv[j]};
      ge[j]   = tr[j] >= {1'b0, dv[j]};
    end
  end

  always_comb begin
    mq = ov[QMW] ? {1'b1, {QMW{1'b0}}} : {1'b0, qn[QMW]};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem[0] <= nu >> QINT;
      qn[0]  <= {nu[QINT-1:0], {FRAC{1'b0}}};
      dv[0]  <= du;
      sg[0]  <= num[PW-1] ^ den[PW-1];
      ov[0]  <= (nu >> QINT) >= du;
      for (int j = 0; j < QMW; j++) begin
        rem[j+1] <= ge[j] ? tsub[j][PW-1:0] : tr[j][PW-1:0];
        qn[j+1]  <= {qn[j][QMW-2:0], ge[j]};
        dv[j+1]  <= dv[j];
        sg[j+1]  <= sg[j];
        ov[j+1]  <= ov[j];
      end
      quo <= sg[QMW] ? -QW'({1'b0, mq}) : QW'({1'b0, mq});
    end
  end

endmodule
